// File: hdl/lkvc_pkg.sv
// Shared types, constants and control structs for the LRU key-value cache.
package lkvc_pkg;

   // Store geometry
   localparam int ENTRIES   = 16;
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;

   // Operation codes
   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   // Request payload
   typedef struct packed {
      op_type                   opcode;
      logic signed [KEY_W-1:0]  lookup_key;
      logic signed [VAL_W-1:0]  store_value;
   } req_type;

   // Response payload
   typedef struct packed {
      logic                     found;
      logic signed [VAL_W-1:0]  read_value;
      logic                     evicted;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // request transfer: capture item, start scan
      logic commit;  // apply update and load the response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;  // last entry compared this cycle
      logic out_free;   // response register can take a new result
   } status_type;

endpackage

// File: hdl/lkvc_ram.sv
// Generic single-port-write, registered-read RAM.
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lkvc_ctrl.sv
// Sequencer for the cache: accept, scan, update.
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output logic       idle,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      idle       = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idle     = 1'b1;
            cmd.load = req_valid;
         end
         ST_SCAN: begin
         end
         ST_UPDATE: begin
            cmd.commit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hdl/lkvc_datapath.sv
// Key/value storage, sequential tag scan, recency ranks and response register.
module lkvc_datapath import lkvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  req_type          req_data,
   input  logic [CAP_W-1:0] capacity,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   // Captured request
   op_type           op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;

   // Scan pipeline: read issue, then compare in the next cycle
   logic [IDX_W-1:0] rd_idx_ff;
   logic             issue_ff;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;

   // Scan results
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [IDX_W-1:0] hit_rank_ff;
   logic [VAL_W-1:0] hit_val_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic             worst_vld_ff;
   logic [IDX_W-1:0] worst_idx_ff;
   logic [IDX_W-1:0] worst_rank_ff;

   // Per-entry state
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   rank_ff [ENTRIES];
   logic [IDX_W-1:0]   rank_in [ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;

   // Response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // RAM ports
   logic [KEY_W-1:0] key_rd;
   logic [VAL_W-1:0] val_rd;
   logic             key_we, val_we;
   logic [IDX_W-1:0] wr_idx;

   // Compare stage signals
   logic             cmp_valid_entry;
   logic [IDX_W-1:0] cmp_rank;
   logic             cmp_match;

   // Decision signals
   logic [CNT_W-1:0] cap_eff;
   logic             do_insert, do_evict, do_fresh;
   logic             touch_en;
   logic [IDX_W-1:0] touch_idx, touch_rank;
   logic [IDX_W-1:0] slot;

   lkvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_idx),
      .wr_data (key_ff),
      .rd_addr (rd_idx_ff),
      .rd_data (key_rd)
   );

   lkvc_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_idx),
      .wr_data (val_ff),
      .rd_addr (rd_idx_ff),
      .rd_data (val_rd)
   );

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.opcode;
         key_ff <= req_data.lookup_key;
         val_ff <= req_data.store_value;
      end
   end

   // Read issue counter and compare-stage tag
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= issue_ff;
         if (cmd.load) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && rd_idx_ff == IDX_W'(ENTRIES - 1)) begin
            issue_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_idx_ff;
      if (cmd.load) begin
         rd_idx_ff <= '0;
      end else if (issue_ff) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
   end

   // Compare one entry per cycle
   assign cmp_valid_entry = valid_ff[cmp_idx_ff];
   assign cmp_rank        = rank_ff[cmp_idx_ff];
   assign cmp_match       = cmp_valid_entry && (key_rd == key_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         worst_vld_ff <= 1'b0;
      end else if (cmp_vld_ff) begin
         // first matching valid entry
         if (cmp_match && !hit_ff) begin
            hit_ff      <= 1'b1;
            hit_idx_ff  <= cmp_idx_ff;
            hit_rank_ff <= cmp_rank;
            hit_val_ff  <= val_rd;
         end
         // first empty entry
         if (!cmp_valid_entry && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= cmp_idx_ff;
         end
         // oldest valid entry, lowest index on a tie
         if (cmp_valid_entry && (!worst_vld_ff || cmp_rank > worst_rank_ff)) begin
            worst_vld_ff  <= 1'b1;
            worst_idx_ff  <= cmp_idx_ff;
            worst_rank_ff <= cmp_rank;
         end
      end
   end

   assign status.scan_done = cmp_vld_ff && (cmp_idx_ff == IDX_W'(ENTRIES - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Capacity clamped to 1..ENTRIES
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if (CNT_W'(capacity) > CNT_W'(ENTRIES)) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = CNT_W'(capacity);
      end
   end

   // Action decode
   always_comb begin
      do_insert  = 1'b0;
      do_evict   = 1'b0;
      do_fresh   = 1'b0;
      touch_en   = 1'b0;
      touch_idx  = hit_idx_ff;
      touch_rank = hit_rank_ff;
      slot       = free_idx_ff;
      if (hit_ff) begin
         touch_en = 1'b1;
      end else if (op_ff == OP_PUT) begin
         if (count_ff < cap_eff && free_ff) begin
            do_insert = 1'b1;
         end else if (worst_vld_ff) begin
            do_evict   = 1'b1;
            touch_en   = 1'b1;
            touch_idx  = worst_idx_ff;
            touch_rank = worst_rank_ff;
            slot       = worst_idx_ff;
         end else begin
            do_fresh = 1'b1;
            slot     = '0;
         end
      end
   end

   assign key_we = cmd.commit && !hit_ff && (op_ff == OP_PUT);
   assign val_we = cmd.commit && (op_ff == OP_PUT);
   assign wr_idx = hit_ff ? hit_idx_ff : slot;

   // Next valid bits, ranks and count
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (touch_en) begin
            if (IDX_W'(i) == touch_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < touch_rank) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (do_insert) begin
            if (IDX_W'(i) == slot) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (do_fresh) begin
            if (IDX_W'(i) == slot) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end
         end
      end
      if (do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (do_fresh) begin
         count_in = CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rank_ff <= rank_in;
      end
   end

   // Response register
   always_comb begin
      rsp_in.found      = hit_ff;
      rsp_in.read_value = (hit_ff && op_ff == OP_GET) ? hit_val_ff : '0;
      rsp_in.evicted    = do_evict;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: control register, sequencer and datapath.
//
// Fully associative 16-entry key-value store with least-recently-used
// replacement. Each request is a get or a put and yields exactly one response.
// The tag scan reads one entry a cycle from the key/value RAMs (16 reads
// through registered read ports). An update state follows, which applies the
// recency changes and any write. The block then returns to idle and takes no
// new request before the previous one has been committed. A response waits in
// an output register. While the previous response is still stalled there, the
// update state waits and the request input stays stalled. The capacity register
// (reset 16, 0 acts as 1, values above 16 act as 16) may only be written while
// no operation is in flight.
module lru_key_value_cache import lkvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   // capacity register write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_wdata
);

   logic             idle;
   cmd_type          cmd;
   status_type       status;
   logic [CAP_W-1:0] capacity_ff;

   // Capacity register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RESET);
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_wdata;
      end
   end

   assign req_stall = !idle;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .idle      (idle),
      .cmd       (cmd)
   );

   lkvc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .capacity  (capacity_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/sv/lru_key_value_cache_tb.sv
// Self-checking testbench for the LRU key-value cache: directed, random and back-pressure runs.
module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int POOL_SIZE   = 32;
   localparam int DRAIN_WAIT  = 25;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_wdata = '0;

   // Shadow copy of the cache contents and recency order
   logic [KEY_W-1:0] store_key [ENTRIES];
   logic [VAL_W-1:0] store_val [ENTRIES];
   logic             store_live [ENTRIES];
   int unsigned      store_age [ENTRIES];
   int               live_count;
   logic [CAP_W-1:0] capacity_reg;

   rsp_type          pending_rsp[$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   int  req_sent = 0;
   int  rsp_seen = 0;
   int  err_count = 0;
   int  hit_count = 0;
   int  evict_count = 0;
   int  sender_idle_pct = 0;
   int  recv_stall_pct = 0;
   logic hold_on = 1'b0;
   event hold_go;

   always #5 clock = ~clock;

   lru_key_value_cache u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // Move one slot to the front; younger live entries age by one
   function automatic void promote(input int slot, input int unsigned old_age);
      int i;
      for (i = 0; i < ENTRIES; i++) begin
         if (store_live[i] && i != slot && store_age[i] < old_age) store_age[i]++;
      end
      store_age[slot] = 0;
   endfunction

   // Apply one get or put to the shadow cache and return its response
   function automatic rsp_type cache_access(input req_type item);
      rsp_type     res;
      int          i;
      int          hit;
      int          slot;
      int          cap;
      int unsigned worst;
      res  = '0;
      hit  = -1;
      slot = -1;
      cap  = capacity_reg;
      if (cap < 1) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      for (i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && store_live[i] && store_key[i] == item.lookup_key) hit = i;
      end
      if (hit >= 0) begin
         res.found = 1'b1;
         if (item.opcode == OP_PUT) store_val[hit] = item.store_value;
         else res.read_value = store_val[hit];
         promote(hit, store_age[hit]);
      end else if (item.opcode == OP_PUT) begin
         if (live_count < cap) begin
            for (i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && !store_live[i]) slot = i;
            end
         end
         if (slot >= 0) begin
            // free slot: newcomer is younger than everything live
            for (i = 0; i < ENTRIES; i++) begin
               if (store_live[i]) store_age[i]++;
            end
            store_live[slot] = 1'b1;
            store_age[slot]  = 0;
            live_count++;
         end else begin
            // at or over capacity: reuse the oldest slot in place
            worst = 0;
            for (i = 0; i < ENTRIES; i++) begin
               if (store_live[i] && (slot < 0 || store_age[i] > worst)) begin
                  slot  = i;
                  worst = store_age[i];
               end
            end
            res.evicted = 1'b1;
            promote(slot, worst);
         end
         store_key[slot] = item.lookup_key;
         store_val[slot] = item.store_value;
      end
      return res;
   endfunction

   // Scoreboard: predict on request transfer, compare on response transfer
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < ENTRIES; i++) begin
            store_live[i] = 1'b0;
            store_age[i]  = 0;
         end
         live_count   = 0;
         capacity_reg = CAP_W'(CAP_RESET);
      end else begin
         if (csr_valid && csr_ready) capacity_reg = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               err_count++;
               $display("%0t: unexpected response, expected none, got %p", $time, rsp_data);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.found !== want.found) begin
                  err_count++;
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, want.found, rsp_data.found);
               end
               if (rsp_data.read_value !== want.read_value) begin
                  err_count++;
                  $display("%0t: read_value mismatch, expected %h, got %h",
                           $time, want.read_value, rsp_data.read_value);
               end
               if (rsp_data.evicted !== want.evicted) begin
                  err_count++;
                  $display("%0t: evicted mismatch, expected %0b, got %0b",
                           $time, want.evicted, rsp_data.evicted);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = cache_access(req_data);
            if (want.found) hit_count++;
            if (want.evicted) evict_count++;
            pending_rsp.push_back(want);
         end
      end
   end

   // Response stall: random, or held high for a long stretch on request
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
   end

   initial begin
      forever begin
         @(hold_go);
         hold_on <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   // Run limit
   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_type make_req(input op_type op, input logic [KEY_W-1:0] key,
                                        input logic [VAL_W-1:0] val);
      req_type item;
      item.opcode      = op;
      item.lookup_key  = key;
      item.store_value = val;
      return item;
   endfunction

   // Mostly keys from a small working set so that hits and evictions occur
   function automatic req_type random_req(input int span);
      req_type item;
      item.opcode = $urandom_range(1) ? OP_PUT : OP_GET;
      if ($urandom_range(9) == 0) item.lookup_key = $urandom();
      else item.lookup_key = key_pool[$urandom_range(span - 1)];
      item.store_value = $urandom();
      return item;
   endfunction

   // Offer one request; called at a clock edge, returns at one
   task automatic send_req(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_sent++;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic park_sender();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (rsp_seen < req_sent) @(posedge clock);
   endtask

   // Capacity write, only once the block has gone idle
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      park_sender();
      wait_drain();
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Extreme keys and values, get/put hit and miss at reset capacity
   task automatic test_basic_ops();
      send_req(make_req(OP_GET, 32'h7fff_ffff, 32'h0));
      send_req(make_req(OP_PUT, 32'h7fff_ffff, 32'h7fff_ffff));
      send_req(make_req(OP_PUT, 32'h8000_0000, 32'h8000_0000));
      send_req(make_req(OP_PUT, 32'h0000_0000, 32'h0000_0000));
      send_req(make_req(OP_PUT, 32'hffff_ffff, 32'hffff_ffff));
      send_req(make_req(OP_GET, 32'h8000_0000, 32'hffff_ffff));
      send_req(make_req(OP_PUT, 32'h7fff_ffff, 32'h1234_5678));
      send_req(make_req(OP_GET, 32'h7fff_ffff, 32'h0));
      send_req(make_req(OP_GET, 32'h0000_0000, 32'h0));
      send_req(make_req(OP_GET, 32'h0000_0001, 32'h0));
      park_sender();
   endtask

   // Capacity below the live count, zero acting as one, above the entry count
   task automatic test_capacity_limits();
      write_capacity(5'd2);
      send_req(make_req(OP_PUT, 32'd5, 32'hdead_0005));
      send_req(make_req(OP_PUT, 32'd6, 32'hdead_0006));
      send_req(make_req(OP_GET, 32'd5, 32'h0));
      send_req(make_req(OP_PUT, 32'd7, 32'hdead_0007));
      write_capacity(5'd0);
      send_req(make_req(OP_PUT, 32'd8, 32'hdead_0008));
      send_req(make_req(OP_GET, 32'd8, 32'h0));
      write_capacity(5'd31);
      send_req(make_req(OP_PUT, 32'd9, 32'hdead_0009));
      send_req(make_req(OP_PUT, 32'd10, 32'hdead_000a));
      send_req(make_req(OP_GET, 32'd9, 32'h0));
      park_sender();
   endtask

   task automatic test_random_traffic(input int count, input logic [CAP_W-1:0] cap,
                                      input int s_idle, input int r_stall, input int span);
      int n;
      write_capacity(cap);
      sender_idle_pct = s_idle;
      recv_stall_pct  = r_stall;
      for (n = 0; n < count; n++) send_req(random_req(span));
      park_sender();
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_backpressure(input int count);
      int n;
      write_capacity(5'd8);
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      -> hold_go;
      for (n = 0; n < count; n++) send_req(random_req(12));
      park_sender();
   endtask

   // Sender stops every so often until all responses are back
   task automatic test_sender_pause(input int count);
      int n;
      write_capacity(CAP_W'($urandom_range(1, ENTRIES)));
      sender_idle_pct = 26;
      recv_stall_pct  = 26;
      for (n = 0; n < count; n++) begin
         if (n % 25 == 24) begin
            park_sender();
            wait_drain();
         end
         send_req(random_req(20));
      end
      park_sender();
   endtask

   initial begin : main
      int k;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hffff_ffff;
      key_pool[2] = 32'h7fff_ffff;
      key_pool[3] = 32'h8000_0000;
      for (k = 4; k < POOL_SIZE; k++) key_pool[k] = $urandom();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_capacity_limits();
      test_random_traffic(350, 5'd16, 0, 0, 20);
      test_random_traffic(350, 5'd4, 81, 0, 7);
      test_random_traffic(250, 5'd1, 0, 81, 3);
      test_random_traffic(350, 5'd31, 26, 26, 24);
      test_random_traffic(150, 5'd0, 0, 0, 3);
      test_backpressure(150);
      test_sender_pause(150);

      wait_drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         err_count++;
         $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
      end
      $display("Covered %0d requests with %0d hits and %0d evictions", req_sent, hit_count,
               evict_count);
      $display("Capacities 0 to 31, mixed idling, a long response hold-off and sender pauses");
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
